// ===== design/assert_macros.svh =====
// assertion macros shared by the rtl files
// no dependencies; included by modules that check their own control logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every edge outside reset
`define CHK_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lesg_pkg.sv =====
// constants and arithmetic helpers for the lorenz euler step generator
// no dependencies; imported by lorenz_euler_step_generator
package lesg_pkg;

    localparam int QW      = 32;
    localparam int FRAC    = 20;
    localparam int DT_W    = 21;
    localparam int LEN_W   = 16;
    localparam int IDX_W   = 3;
    localparam int TDATA_W = 120;

    localparam logic signed [QW-1:0] Q_ONE       = 32'sd1048576;
    localparam logic signed [QW-1:0] SIGMA_RST   = 32'sd10485760;
    localparam logic signed [QW-1:0] BETA_RST    = 32'sd2796164;
    localparam logic signed [QW-1:0] RHO_RST     = 32'sd29360128;
    localparam logic [DT_W-1:0]      DT_RST      = 21'd1049;
    localparam logic [LEN_W-1:0]     LEN_RST     = 16'd50000;

    localparam logic [IDX_W-1:0] REG_SIGMA = 3'd0;
    localparam logic [IDX_W-1:0] REG_BETA  = 3'd1;
    localparam logic [IDX_W-1:0] REG_RHO   = 3'd2;
    localparam logic [IDX_W-1:0] REG_DT    = 3'd3;
    localparam logic [IDX_W-1:0] REG_LEN   = 3'd4;

    localparam logic signed [QW-1:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [QW-1:0] S32_MIN = 32'sh80000000;

    // saturating add or subtract of two q12.20 values
    function automatic logic signed [QW-1:0] sat_addsub(
        input logic signed [QW-1:0] a,
        input logic signed [QW-1:0] b,
        input logic                 sub
    );
        logic signed [QW:0] s;
        s = sub ? ({a[QW-1], a} - {b[QW-1], b}) : ({a[QW-1], a} + {b[QW-1], b});
        if (s[QW] != s[QW-1]) begin
            return s[QW] ? S32_MIN : S32_MAX;
        end
        return s[QW-1:0];
    endfunction

    // product shifted down by the fraction width, floor rounding, saturated
    function automatic logic signed [QW-1:0] prod_sat(input logic signed [2*QW-1:0] p);
        logic [2*QW-1:FRAC+QW-1] top;
        top = p[2*QW-1:FRAC+QW-1];
        if ((top != '0) && (top != '1)) begin
            return p[2*QW-1] ? S32_MIN : S32_MAX;
        end
        return p[FRAC+QW-1:FRAC];
    endfunction

    // 16-bit value modulo 255 by folding bytes
    function automatic logic [7:0] mod255(input logic [LEN_W-1:0] v);
        logic [8:0] s1;
        logic [8:0] s2;
        s1 = {1'b0, v[15:8]} + {1'b0, v[7:0]};
        s2 = {8'd0, s1[8]} + {1'b0, s1[7:0]};
        return (s2 >= 9'd255) ? 8'd0 : s2[7:0];
    endfunction

endpackage

// ===== design/lorenz_euler_step_generator.sv =====
// lorenz euler step generator: one explicit euler step per request
// depends on lesg_pkg and assert_macros.svh
//
//  channel   direction  payload
//  s_        in         tdata[0] restart
//  m_        out        tdata half_x, half_y, half_z, red, green, blue; tlast final step
//  cfg_      in         cfg_index register, cfg_data value
//
// a request passes from acceptance through one subtract, seven products through the
// single 32x32 multiplier and the last update before its result is loaded; s_tready is
// high only while the sequencer is idle, so a new request waits until the last one is done.
// a waiting result does not block acceptance; the last update holds until it is taken.
// reset restores the point (1,1,1), step index 0 and the register defaults.
`include "assert_macros.svh"

module lorenz_euler_step_generator
    import lesg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [0] restart, rest zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // half_x, half_y, half_z, red, green, blue, pad
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [QW-1:0]        cfg_data
);

    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_DIFF = 4'd1;
    localparam logic [3:0] PH_M1   = 4'd2;
    localparam logic [3:0] PH_M2   = 4'd3;
    localparam logic [3:0] PH_M3   = 4'd4;
    localparam logic [3:0] PH_M4   = 4'd5;
    localparam logic [3:0] PH_M5   = 4'd6;
    localparam logic [3:0] PH_M6   = 4'd7;
    localparam logic [3:0] PH_M7   = 4'd8;
    localparam logic [3:0] PH_FIN  = 4'd9;

    logic [3:0]               phase_reg;
    logic signed [QW-1:0]     sigma_reg, beta_reg, rho_reg;
    logic [DT_W-1:0]          dt_reg;
    logic [LEN_W-1:0]         len_reg;
    logic signed [QW-1:0]     pos_x_reg, pos_y_reg, pos_z_reg;
    logic [LEN_W-1:0]         idx_reg;
    logic signed [QW-1:0]     dxy_reg, drz_reg, dx_reg, dy_reg, xy_reg, dz_reg;
    logic signed [2*QW-1:0]   prod_reg;
    logic                     m_tvalid_reg;
    logic [TDATA_W-1:0]       m_tdata_reg;
    logic                     m_tlast_reg;

    logic signed [QW-1:0]     mul_a, mul_b;
    logic signed [2*QW-1:0]   prod_next;
    logic signed [QW-1:0]     q;
    logic signed [QW-1:0]     alu_a, alu_b;
    logic                     alu_sub;
    logic signed [QW-1:0]     alu_res;
    logic signed [QW-1:0]     dt_q;
    logic                     in_go, fin_go, last;
    logic [LEN_W:0]           idx_inc;
    logic [TDATA_W-1:0]       out_next;

    assign s_tready  = (phase_reg == PH_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

    assign in_go   = s_tvalid && s_tready;
    assign fin_go  = (phase_reg == PH_FIN) && (!m_tvalid_reg || m_tready);
    assign dt_q    = {{(QW-DT_W){1'b0}}, dt_reg};
    assign idx_inc = {1'b0, idx_reg} + {{LEN_W{1'b0}}, 1'b1};
    assign last    = (idx_inc >= {1'b0, len_reg});
    assign q       = prod_sat(prod_reg);

    // multiplier operand select
    always_comb begin
        unique case (phase_reg)
            PH_M1:   begin mul_a = sigma_reg; mul_b = dxy_reg;   end
            PH_M2:   begin mul_a = pos_x_reg; mul_b = drz_reg;   end
            PH_M3:   begin mul_a = pos_x_reg; mul_b = pos_y_reg; end
            PH_M4:   begin mul_a = beta_reg;  mul_b = pos_z_reg; end
            PH_M5:   begin mul_a = dt_q;      mul_b = dx_reg;    end
            PH_M6:   begin mul_a = dt_q;      mul_b = dy_reg;    end
            PH_M7:   begin mul_a = dt_q;      mul_b = dz_reg;    end
            default: begin mul_a = '0;        mul_b = '0;        end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // adder operand select; from PH_M2 on it consumes the product of the previous phase
    always_comb begin
        alu_sub = 1'b0;
        unique case (phase_reg)
            PH_DIFF: begin alu_a = pos_y_reg; alu_b = pos_x_reg; alu_sub = 1'b1; end
            PH_M1:   begin alu_a = rho_reg;   alu_b = pos_z_reg; alu_sub = 1'b1; end
            PH_M2:   begin alu_a = q;         alu_b = '0;                        end
            PH_M3:   begin alu_a = q;         alu_b = pos_y_reg; alu_sub = 1'b1; end
            PH_M4:   begin alu_a = q;         alu_b = '0;                        end
            PH_M5:   begin alu_a = xy_reg;    alu_b = q;         alu_sub = 1'b1; end
            PH_M6:   begin alu_a = pos_x_reg; alu_b = q;                         end
            PH_M7:   begin alu_a = pos_y_reg; alu_b = q;                         end
            PH_FIN:  begin alu_a = pos_z_reg; alu_b = q;                         end
            default: begin alu_a = '0;        alu_b = '0;                        end
        endcase
    end

    assign alu_res = sat_addsub(alu_a, alu_b, alu_sub);

    assign out_next = {3'b000,
                       idx_reg[5:0],
                       idx_reg[6:0],
                       mod255(idx_reg),
                       alu_res[QW-1], alu_res[QW-1:1],
                       pos_y_reg[QW-1], pos_y_reg[QW-1:1],
                       pos_x_reg[QW-1], pos_x_reg[QW-1:1]};

    always_ff @(posedge aclk) begin
        // dt*dz product stays put while the final phase waits
        if (phase_reg != PH_FIN) begin
            prod_reg <= prod_next;
        end
        unique case (phase_reg)
            PH_DIFF: dxy_reg <= alu_res;
            PH_M1:   drz_reg <= alu_res;
            PH_M2:   dx_reg  <= alu_res;
            PH_M3:   dy_reg  <= alu_res;
            PH_M4:   xy_reg  <= alu_res;
            PH_M5:   dz_reg  <= alu_res;
            default: ;
        endcase
        if (fin_go) begin
            m_tdata_reg <= out_next;
            m_tlast_reg <= last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            sigma_reg    <= SIGMA_RST;
            beta_reg     <= BETA_RST;
            rho_reg      <= RHO_RST;
            dt_reg       <= DT_RST;
            len_reg      <= LEN_RST;
            pos_x_reg    <= Q_ONE;
            pos_y_reg    <= Q_ONE;
            pos_z_reg    <= Q_ONE;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_SIGMA: sigma_reg <= cfg_data;
                    REG_BETA:  beta_reg  <= cfg_data;
                    REG_RHO:   rho_reg   <= cfg_data;
                    REG_DT:    dt_reg    <= cfg_data[DT_W-1:0];
                    REG_LEN:   len_reg   <= cfg_data[LEN_W-1:0];
                    default:   ;
                endcase
            end

            if (fin_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (phase_reg)
                PH_IDLE: begin
                    if (in_go) begin
                        phase_reg <= PH_DIFF;
                        if (s_tdata[0]) begin
                            pos_x_reg <= Q_ONE;
                            pos_y_reg <= Q_ONE;
                            pos_z_reg <= Q_ONE;
                            idx_reg   <= '0;
                        end
                    end
                end
                PH_M6: begin
                    pos_x_reg <= alu_res;
                    phase_reg <= PH_M7;
                end
                PH_M7: begin
                    pos_y_reg <= alu_res;
                    phase_reg <= PH_FIN;
                end
                PH_FIN: begin
                    if (fin_go) begin
                        phase_reg <= PH_IDLE;
                        if (last) begin
                            pos_x_reg <= Q_ONE;
                            pos_y_reg <= Q_ONE;
                            pos_z_reg <= Q_ONE;
                            idx_reg   <= '0;
                        end else begin
                            pos_z_reg <= alu_res;
                            idx_reg   <= idx_inc[LEN_W-1:0];
                        end
                    end
                end
                PH_DIFF, PH_M1, PH_M2, PH_M3, PH_M4, PH_M5: begin
                    phase_reg <= phase_reg + 4'd1;
                end
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    `CHK_NEXT(a_accept_starts, aclk, aresetn, in_go, phase_reg == PH_DIFF, "request did not start the sequence")
    `CHK_IMPL(a_result_from_fin, aclk, aresetn, $rose(m_tvalid_reg), $past(phase_reg) == PH_FIN, "result loaded outside the final phase")
    `CHK_NEXT(a_last_restarts, aclk, aresetn, fin_go && last, (idx_reg == '0) && (pos_x_reg == Q_ONE) && (pos_z_reg == Q_ONE), "trajectory did not restart after its last step")

endmodule

// ===== verif/tb.sv =====
// testbench for lorenz_euler_step_generator: random and directed euler steps
// checked against an in-bench fixed point predictor; depends on lesg_pkg and the rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lesg_pkg::*;

    localparam int LATENCY = 10;
    localparam int MAX_WAIT = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 650;
    localparam logic [DT_W-1:0] DT_MAX = '1;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;
    localparam int REG_TOP = (1 << IDX_W) - 1;

    typedef struct {
        logic [31:0] hx;
        logic [31:0] hy;
        logic [31:0] hz;
        logic [7:0]  red;
        logic [6:0]  green;
        logic [5:0]  blue;
        logic        last;
    } lorenz_point_t;

    class lorenz_scoreboard;
        longint sigma_q, beta_q, rho_q, dt_q;
        int unsigned length;
        longint px, py, pz;
        int unsigned index;
        lorenz_point_t expected_points[$];
        int errors, steps, results, finals, restarts;

        function new();
            sigma_q = SIGMA_RST;
            beta_q = BETA_RST;
            rho_q = RHO_RST;
            dt_q = DT_RST;
            length = LEN_RST;
            home();
        endfunction

        function void home();
            px = Q_ONE;
            py = Q_ONE;
            pz = Q_ONE;
            index = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > longint'(S32_MAX)) return longint'(S32_MAX);
            if (v < longint'(S32_MIN)) return longint'(S32_MIN);
            return v;
        endfunction

        function longint qmul_sat(longint a, longint b);
            return clamp32((a * b) >>> FRAC);
        endfunction

        function void apply_config(logic [IDX_W-1:0] idx, logic [QW-1:0] data);
            case (idx)
                REG_SIGMA: sigma_q = longint'($signed(data));
                REG_BETA:  beta_q = longint'($signed(data));
                REG_RHO:   rho_q = longint'($signed(data));
                REG_DT:    dt_q = longint'(data[DT_W-1:0]);
                REG_LEN:   length = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic restart);
            longint dx, dy, dz;
            lorenz_point_t p;
            steps++;
            if (restart) begin
                restarts++;
                home();
            end
            dx = qmul_sat(sigma_q, clamp32(py - px));
            dy = clamp32(qmul_sat(px, clamp32(rho_q - pz)) - py);
            dz = clamp32(qmul_sat(px, py) - qmul_sat(beta_q, pz));
            px = clamp32(px + qmul_sat(dt_q, dx));
            py = clamp32(py + qmul_sat(dt_q, dy));
            pz = clamp32(pz + qmul_sat(dt_q, dz));
            p.hx = px[32:1];
            p.hy = py[32:1];
            p.hz = pz[32:1];
            p.red = 8'(index % 255);
            p.green = 7'(index % 128);
            p.blue = 6'(index % 64);
            p.last = (index + 1 >= length);
            if (p.last) begin
                finals++;
                home();
            end else begin
                index++;
            end
            expected_points.push_back(p);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at result %0d: %s", results, msg);
        endtask

        task check_result(logic [TDATA_W-1:0] data, logic last);
            lorenz_point_t e;
            logic [31:0] got[7];
            logic [31:0] want[7];
            string names[7];
            results++;
            if (expected_points.size() == 0) begin
                report("result with no request waiting");
                return;
            end
            e = expected_points.pop_front();
            names = '{"half_x", "half_y", "half_z", "red", "green", "blue", "final_step"};
            got = '{data[31:0], data[63:32], data[95:64], 32'(data[103:96]),
                    32'(data[110:104]), 32'(data[116:111]), 32'(last)};
            want = '{e.hx, e.hy, e.hz, 32'(e.red), 32'(e.green), 32'(e.blue), 32'(e.last)};
            for (int i = 0; i < 7; i++) begin
                if (got[i] !== want[i]) begin
                    report($sformatf("%s got %0h expected %0h", names[i], got[i], want[i]));
                end
            end
        endtask

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // [0] restart, rest zero
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;   // half_x, half_y, half_z, red, green, blue, pad
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index;
    logic [QW-1:0]        cfg_data;

    lorenz_scoreboard sb;
    bit steady = 1'b0;
    int cycles = 0;
    int settings_used = 0;

    lorenz_euler_step_generator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_request(input logic restart);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, restart};
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_request(restart);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [QW-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.apply_config(idx, value);
    endtask

    task automatic set_registers(input logic [QW-1:0] sig, input logic [QW-1:0] bet,
                                 input logic [QW-1:0] rh, input logic [QW-1:0] dtv,
                                 input logic [QW-1:0] lenv, input bit len_only);
        if (!len_only) begin
            write_reg(REG_SIGMA, sig);
            write_reg(REG_BETA, bet);
            write_reg(REG_RHO, rh);
            write_reg(REG_DT, dtv);
        end
        write_reg(REG_LEN, lenv);
        if (!len_only) begin
            write_reg(IDX_W'($urandom_range(REG_LEN + 1, REG_TOP)), $urandom);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input int count, input int restart_odds);
        for (int i = 0; i < count; i++) begin
            send_request(restart_odds > 0 && $urandom_range(1, restart_odds) == 1);
        end
        drain();
    endtask

    function automatic logic [QW-1:0] extreme_word();
        case ($urandom_range(0, 3))
            0: return S32_MAX;
            1: return S32_MIN;
            2: return Q_ONE;
            default: return '0;
        endcase
    endfunction

    task automatic random_settings();
        logic [QW-1:0] sig, bet, rh, dtv, lenv;
        case ($urandom_range(0, 3))
            0: begin
                sig = $urandom_range(6 * Q_ONE, 14 * Q_ONE);
                bet = $urandom_range(Q_ONE, 4 * Q_ONE);
                rh = $urandom_range(20 * Q_ONE, 40 * Q_ONE);
                dtv = $urandom_range(100, 20000);
                lenv = $urandom_range(0, 1) ? QW'(LEN_MAX) : $urandom_range(1, 400);
            end
            1: begin
                sig = $urandom;
                bet = $urandom;
                rh = $urandom;
                dtv = $urandom;
                lenv = $urandom;
            end
            2: begin
                sig = extreme_word();
                bet = extreme_word();
                rh = extreme_word();
                dtv = $urandom_range(0, 1) ? QW'(DT_MAX) : '0;
                lenv = $urandom_range(0, 1) ? QW'(LEN_MAX) : $urandom_range(0, 1);
            end
            default: begin
                sig = $urandom_range(0, 20 * Q_ONE);
                bet = $urandom_range(0, 8 * Q_ONE);
                rh = $urandom_range(0, 60 * Q_ONE);
                dtv = $urandom_range(Q_ONE, DT_MAX);
                lenv = $urandom_range(1, 30);
            end
        endcase
        set_registers(sig, bet, rh, dtv, lenv, 1'b0);
    endtask

    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_result(m_tdata, m_tlast);
        end
    end

    initial begin
        int random_sent;
        int count;
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // default registers straight out of reset
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        drain();

        // saturating coefficients, oversized step, zero length
        set_registers(S32_MAX, S32_MIN, S32_MAX, QW'(DT_MAX), '0, 1'b0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        drain();

        set_registers(S32_MIN, S32_MAX, S32_MIN, '0, 32'd1, 1'b0);
        send_request(1'b0);
        send_request(1'b1);
        drain();

        // unit step drives the point into saturation
        set_registers(SIGMA_RST, BETA_RST, RHO_RST, Q_ONE, QW'(LEN_MAX), 1'b0);
        run_phase(8, 0);

        // length drops below the running index
        set_registers('0, '0, '0, '0, 32'd3, 1'b1);
        run_phase(2, 0);

        // long trajectory to sweep the colour counters
        set_registers(SIGMA_RST, BETA_RST, RHO_RST, 32'd4000, QW'(LEN_MAX), 1'b0);
        run_phase(300, 0);
        random_sent = 300;

        while (random_sent < RANDOM_ITEMS) begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0) begin
                set_registers('0, '0, '0, '0, $urandom_range(1, 60), 1'b1);
            end else begin
                random_settings();
            end
            count = $urandom_range(20, 80);
            run_phase(count, $urandom_range(0, 1) ? 32 : 3);
            random_sent += count;
        end

        $display("covered %0d steps under %0d register settings", sb.steps, settings_used);
        $display("%0d restarts requested, %0d trajectory ends, %0d results checked",
                 sb.restarts, sb.finals, sb.results);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
